[design/hlcfr_pkg.sv]
// Shared types, codes and constants of the header/length/CRC frame receiver.
`timescale 1ns / 1ps

package hlcfr_pkg;

  // Receiver phase; the receiving phases run from PH_HDR0 through PH_CRC1 in order.
  typedef enum logic [3:0] {
    PH_IDLE,
    PH_HDR0,
    PH_HDR1,
    PH_LEN,
    PH_DATA,
    PH_CRC0,
    PH_CRC1,
    PH_DONE,
    PH_CRCERR,
    PH_OVF,
    PH_TMO
  } phase_t;

  // Kind of an input item.
  typedef enum logic [1:0] {
    MODE_BYTE,
    MODE_ARM,
    MODE_TICK,
    MODE_STOP
  } mode_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_HEADER_FIRST,
    CFG_HEADER_SECOND,
    CFG_CRC_ENABLE,
    CFG_MAX_PAYLOAD,
    CFG_TIMEOUT_TICKS
  } cfg_idx_t;

  // Reported status codes.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HUNT,
    ST_PAYLOAD,
    ST_CRC,
    ST_COMPLETE,
    ST_CRC_ERROR,
    ST_OVERFLOW,
    ST_TIMEOUT
  } status_t;

  // Decoded reply kinds.
  localparam logic [1:0] KIND_OTHER = 2'd0;
  localparam logic [1:0] KIND_REG   = 2'd1;
  localparam logic [1:0] KIND_VAR   = 2'd2;

  // First payload byte of a register reply and of a variable reply.
  localparam logic [7:0] REPLY_REG_CODE = 8'h81;
  localparam logic [7:0] REPLY_VAR_CODE = 8'h83;

  // CRC-16 reflected polynomial.
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Configuration reset values.
  localparam logic [7:0]  RST_HEADER_FIRST  = 8'h5A;
  localparam logic [7:0]  RST_HEADER_SECOND = 8'hA5;
  localparam logic        RST_CRC_ENABLE    = 1'b1;
  localparam logic [7:0]  RST_MAX_PAYLOAD   = 8'd255;
  localparam logic [15:0] RST_TIMEOUT_TICKS = 16'd1000;

  // Configuration seen by the control logic.
  typedef struct packed {
    logic [7:0]  header_first;
    logic [7:0]  header_second;
    logic        crc_enable;
    logic [7:0]  max_payload;
    logic [15:0] timeout_ticks;
  } cfg_t;

  // One result item.
  typedef struct packed {
    status_t     status;
    logic        byte_valid;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic        frame_done;
    logic [1:0]  reply_kind;
    logic [15:0] reply_address;
    logic [7:0]  reply_count;
  } res_t;

  // Map a phase to the status code reported for it.
  function automatic status_t status_of(phase_t ph);
    status_t st;
    unique case (ph)
      PH_HDR0, PH_HDR1, PH_LEN: st = ST_HUNT;
      PH_DATA:                  st = ST_PAYLOAD;
      PH_CRC0, PH_CRC1:         st = ST_CRC;
      PH_DONE:                  st = ST_COMPLETE;
      PH_CRCERR:                st = ST_CRC_ERROR;
      PH_OVF:                   st = ST_OVERFLOW;
      PH_TMO:                   st = ST_TIMEOUT;
      default:                  st = ST_IDLE;
    endcase
    return st;
  endfunction

endpackage

[design/header_length_crc_frame_receiver.sv]
// Top level: configuration registers, stream handshake and result register.
// A result is presented in the cycle after its input transfer.
// Throughput: one item per cycle; the whole frame step (state machine,
// bytewise CRC update and reply decode) is one combinational pass into the
// result register. The output register stalls the input only while full and
// not being taken. Reset is synchronous, active low, restores the register
// defaults and leaves the receiver idle with the timer stopped.
`timescale 1ns / 1ps

module header_length_crc_frame_receiver (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic [1:0]  in_tuser,   // [1:0] mode
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // [2:0] status, [10:3] payload_byte, [18:11] payload_index,
  // [20:19] reply_kind, [36:21] reply_address, [44:37] reply_count, [47:45] zero
  output logic [47:0] out_tdata,
  output logic        out_tuser,  // [0] byte_valid
  output logic        out_tlast,  // frame_done
  // Configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  hlcfr_pkg::cfg_t cfg_r;
  hlcfr_pkg::res_t res_c;
  hlcfr_pkg::res_t res_r;
  logic            out_valid_r, out_valid_nxt;
  logic            in_xfer;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_first  <= hlcfr_pkg::RST_HEADER_FIRST;
      cfg_r.header_second <= hlcfr_pkg::RST_HEADER_SECOND;
      cfg_r.crc_enable    <= hlcfr_pkg::RST_CRC_ENABLE;
      cfg_r.max_payload   <= hlcfr_pkg::RST_MAX_PAYLOAD;
      cfg_r.timeout_ticks <= hlcfr_pkg::RST_TIMEOUT_TICKS;
    end else if (cfg_we) begin
      unique case (hlcfr_pkg::cfg_idx_t'(cfg_index))
        hlcfr_pkg::CFG_HEADER_FIRST:  cfg_r.header_first  <= cfg_wdata[7:0];
        hlcfr_pkg::CFG_HEADER_SECOND: cfg_r.header_second <= cfg_wdata[7:0];
        hlcfr_pkg::CFG_CRC_ENABLE:    cfg_r.crc_enable    <= cfg_wdata[0];
        hlcfr_pkg::CFG_MAX_PAYLOAD:   cfg_r.max_payload   <= cfg_wdata[7:0];
        hlcfr_pkg::CFG_TIMEOUT_TICKS: cfg_r.timeout_ticks <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input transfer whenever the result register is free or draining.
  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;

  hlcfr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_i    (in_xfer),
    .mode_i    (hlcfr_pkg::mode_t'(in_tuser)),
    .rx_byte_i (in_tdata),
    .cfg_i     (cfg_r),
    .res_o     (res_c)
  );

  // Result register valid flag.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_xfer) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload is loaded on each input transfer.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res_r <= res_c;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.byte_valid;
  assign out_tlast  = res_r.frame_done;
  assign out_tdata  = {3'b000, res_r.reply_count, res_r.reply_address, res_r.reply_kind,
                       res_r.payload_index, res_r.payload_byte, res_r.status};

endmodule

[design/hlcfr_crc16.sv]
// Bytewise update of the reflected CRC-16 (polynomial 0xA001).
`timescale 1ns / 1ps

module hlcfr_crc16 (
  input  logic [15:0] crc_i,
  input  logic [7:0]  byte_i,
  output logic [15:0] crc_o
);

  // Eight shift-and-xor steps, one per data bit, least significant bit first.
  always_comb begin
    logic [15:0] c;
    c = crc_i ^ {8'h00, byte_i};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ hlcfr_pkg::CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_o = c;
  end

endmodule

[design/hlcfr_ctrl.sv]
// Frame state machine, timeout counter, reply decoder and result formation.
`timescale 1ns / 1ps

module hlcfr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_i,
  input  hlcfr_pkg::mode_t  mode_i,
  input  logic [7:0]        rx_byte_i,
  input  hlcfr_pkg::cfg_t   cfg_i,
  output hlcfr_pkg::res_t   res_o
);

  hlcfr_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  frame_length_r, frame_length_nxt;
  logic [7:0]  byte_position_r, byte_position_nxt;
  logic [15:0] running_crc_r, running_crc_nxt;
  logic [7:0]  crc_low_r, crc_low_nxt;
  logic [15:0] timeout_count_r, timeout_count_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [15:0] address_r, address_nxt;
  logic [7:0]  count_r, count_nxt;

  logic [15:0] crc_upd;
  logic [7:0]  pos_inc;
  logic        last_byte;
  logic        crc_match;
  logic        len_bad;
  logic        receiving;
  logic        tmo_expire;

  // CRC of the payload including the current byte.
  hlcfr_crc16 u_crc (
    .crc_i  (running_crc_r),
    .byte_i (rx_byte_i),
    .crc_o  (crc_upd)
  );

  // Shared conditions.
  assign pos_inc    = byte_position_r + 8'd1;
  assign last_byte  = (pos_inc == frame_length_r);
  assign crc_match  = ({rx_byte_i, crc_low_r} == running_crc_r);
  assign len_bad    = (rx_byte_i == 8'd0) || (rx_byte_i > cfg_i.max_payload);
  assign receiving  = (phase_r >= hlcfr_pkg::PH_HDR0) && (phase_r <= hlcfr_pkg::PH_CRC1);
  assign tmo_expire = (timeout_count_r == 16'd1) && receiving;

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    unique case (mode_i)
      hlcfr_pkg::MODE_ARM:  phase_nxt = hlcfr_pkg::PH_HDR0;
      hlcfr_pkg::MODE_STOP: phase_nxt = hlcfr_pkg::PH_IDLE;
      hlcfr_pkg::MODE_TICK: begin
        if (tmo_expire) begin
          phase_nxt = hlcfr_pkg::PH_TMO;
        end
      end
      default: begin
        unique case (phase_r)
          hlcfr_pkg::PH_HDR0: begin
            phase_nxt = (rx_byte_i == cfg_i.header_first) ? hlcfr_pkg::PH_HDR1
                                                           : hlcfr_pkg::PH_HDR0;
          end
          hlcfr_pkg::PH_HDR1: begin
            phase_nxt = (rx_byte_i == cfg_i.header_second) ? hlcfr_pkg::PH_LEN
                                                            : hlcfr_pkg::PH_HDR0;
          end
          hlcfr_pkg::PH_LEN: begin
            phase_nxt = len_bad ? hlcfr_pkg::PH_OVF : hlcfr_pkg::PH_DATA;
          end
          hlcfr_pkg::PH_DATA: begin
            if (last_byte) begin
              phase_nxt = cfg_i.crc_enable ? hlcfr_pkg::PH_CRC0 : hlcfr_pkg::PH_DONE;
            end
          end
          hlcfr_pkg::PH_CRC0: phase_nxt = hlcfr_pkg::PH_CRC1;
          hlcfr_pkg::PH_CRC1: begin
            phase_nxt = crc_match ? hlcfr_pkg::PH_DONE : hlcfr_pkg::PH_CRCERR;
          end
          default: phase_nxt = phase_r;
        endcase
      end
    endcase
  end

  // Counters, CRC, decoder and result fields.
  always_comb begin
    frame_length_nxt  = frame_length_r;
    byte_position_nxt = byte_position_r;
    running_crc_nxt   = running_crc_r;
    crc_low_nxt       = crc_low_r;
    timeout_count_nxt = timeout_count_r;
    kind_nxt          = kind_r;
    address_nxt       = address_r;
    count_nxt         = count_r;
    res_o             = '0;

    unique case (mode_i)
      hlcfr_pkg::MODE_ARM: begin
        frame_length_nxt  = '0;
        byte_position_nxt = '0;
        running_crc_nxt   = '0;
        crc_low_nxt       = '0;
        timeout_count_nxt = cfg_i.timeout_ticks;
        kind_nxt          = hlcfr_pkg::KIND_OTHER;
        address_nxt       = '0;
        count_nxt         = '0;
      end
      hlcfr_pkg::MODE_STOP: timeout_count_nxt = '0;
      hlcfr_pkg::MODE_TICK: begin
        if (timeout_count_r != 16'd0) begin
          timeout_count_nxt = timeout_count_r - 16'd1;
        end
      end
      default: begin
        case (phase_r)
          hlcfr_pkg::PH_LEN: begin
            frame_length_nxt  = rx_byte_i;
            byte_position_nxt = '0;
            running_crc_nxt   = '0;
            crc_low_nxt       = '0;
            kind_nxt          = hlcfr_pkg::KIND_OTHER;
            address_nxt       = '0;
            count_nxt         = '0;
          end
          hlcfr_pkg::PH_DATA: begin
            res_o.byte_valid    = 1'b1;
            res_o.payload_byte  = rx_byte_i;
            res_o.payload_index = byte_position_r;
            res_o.frame_done    = last_byte && !cfg_i.crc_enable;
            running_crc_nxt     = crc_upd;
            byte_position_nxt   = pos_inc;
            // Reply decode from the leading payload bytes.
            if (byte_position_r == 8'd0) begin
              if (rx_byte_i == hlcfr_pkg::REPLY_REG_CODE) begin
                kind_nxt = hlcfr_pkg::KIND_REG;
              end else if (rx_byte_i == hlcfr_pkg::REPLY_VAR_CODE) begin
                kind_nxt = hlcfr_pkg::KIND_VAR;
              end else begin
                kind_nxt = hlcfr_pkg::KIND_OTHER;
              end
            end else if (kind_r == hlcfr_pkg::KIND_REG) begin
              if (byte_position_r == 8'd1) begin
                address_nxt = {8'h00, rx_byte_i};
              end else if (byte_position_r == 8'd2) begin
                count_nxt = rx_byte_i;
              end
            end else if (kind_r == hlcfr_pkg::KIND_VAR) begin
              if (byte_position_r == 8'd1) begin
                address_nxt = {rx_byte_i, 8'h00};
              end else if (byte_position_r == 8'd2) begin
                address_nxt = address_r | {8'h00, rx_byte_i};
              end else if (byte_position_r == 8'd3) begin
                count_nxt = rx_byte_i;
              end
            end
          end
          hlcfr_pkg::PH_CRC0: crc_low_nxt = rx_byte_i;
          hlcfr_pkg::PH_CRC1: res_o.frame_done = crc_match;
          default: ;
        endcase
      end
    endcase

    res_o.status        = hlcfr_pkg::status_of(phase_nxt);
    res_o.reply_kind    = kind_nxt;
    res_o.reply_address = address_nxt;
    res_o.reply_count   = count_nxt;
  end

  // State registers advance once per accepted item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= hlcfr_pkg::PH_IDLE;
      frame_length_r  <= '0;
      byte_position_r <= '0;
      running_crc_r   <= '0;
      crc_low_r       <= '0;
      timeout_count_r <= '0;
      kind_r          <= hlcfr_pkg::KIND_OTHER;
      address_r       <= '0;
      count_r         <= '0;
    end else if (step_i) begin
      phase_r         <= phase_nxt;
      frame_length_r  <= frame_length_nxt;
      byte_position_r <= byte_position_nxt;
      running_crc_r   <= running_crc_nxt;
      crc_low_r       <= crc_low_nxt;
      timeout_count_r <= timeout_count_nxt;
      kind_r          <= kind_nxt;
      address_r       <= address_nxt;
      count_r         <= count_nxt;
    end
  end

  // An arm transfer restarts header hunting with the timer loaded.
  a_arm_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    step_i && (mode_i == hlcfr_pkg::MODE_ARM) |=>
      (phase_r == hlcfr_pkg::PH_HDR0) && (timeout_count_r == $past(cfg_i.timeout_ticks)))
    else $error("arm did not restart the receiver");

  // A completed frame leaves the receiver in the complete phase.
  a_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
    step_i && res_o.frame_done |=> (phase_r == hlcfr_pkg::PH_DONE))
    else $error("frame completion without complete phase");

  // While payload is expected, the position stays below the frame length.
  a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == hlcfr_pkg::PH_DATA) |-> (byte_position_r < frame_length_r))
    else $error("payload position ran past frame length");

  // A stop transfer idles the receiver and halts the timer.
  a_stop_idles: assert property (@(posedge clk) disable iff (!rst_n)
    step_i && (mode_i == hlcfr_pkg::MODE_STOP) |=>
      (phase_r == hlcfr_pkg::PH_IDLE) && (timeout_count_r == 16'd0))
    else $error("stop did not idle the receiver");

endmodule
